[src/text_mode_glyph_renderer_core_macros.svh]
// assertion helpers for the checker file
`ifndef TEXT_MODE_GLYPH_RENDERER_CORE_MACROS_SVH
`define TEXT_MODE_GLYPH_RENDERER_CORE_MACROS_SVH

// checked only outside reset
`define TMGR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define TMGR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/tmgr_pkg.sv]
package tmgr_pkg;

  localparam int FONT_BYTES   = 9216;
  localparam int TEXT_COLUMNS = 80;
  localparam int BASE_12      = 4096;
  localparam int BASE_8       = 7168;

  localparam int FONT_ADDR_W = 14;
  localparam int ADDR_W      = $clog2(FONT_BYTES);
  localparam int CFG_W       = 7;
  localparam int CFG_IDX_W   = 3;

  localparam int MQ_DEPTH = 4;
  localparam int MQ_PW    = $clog2(MQ_DEPTH);
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PW    = $clog2(OQ_DEPTH);

  typedef enum logic [1:0] {
    CMD_FONT   = 2'd0,
    CMD_RENDER = 2'd1,
    CMD_FRAME  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEIGHT_MODE   = 3'd0,
    REG_INTERACTIVE   = 3'd1,
    REG_CURSOR_SHOWN  = 3'd2,
    REG_CURSOR_BLINKS = 3'd3,
    REG_CURSOR_COL    = 3'd4,
    REG_CURSOR_ROW    = 3'd5,
    REG_ROW_COUNT     = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    HM_16 = 2'd0,
    HM_12 = 2'd1,
    HM_8  = 2'd2
  } height_mode_t;

  typedef logic [3:0]      color_t;
  typedef logic [7:0][3:0] pix_row_t;

  typedef struct packed {
    logic              is_write;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
    logic              line_ok;
    logic              cursor;
    color_t            fg;
    color_t            raw_fg;
    logic [2:0]        bg;
  } op_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

[src/tmgr_ram.sv]
module tmgr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wr_data,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wr_data;
    end
    rd_data_r <= mem[addr];
  end

  assign rd_data = rd_data_r;

endmodule

[src/tmgr_front.sv]
module tmgr_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [tmgr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tmgr_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            push,
  input  logic [1:0]                      in_cmd,
  input  logic [tmgr_pkg::FONT_ADDR_W-1:0] in_font_address,
  input  logic [7:0]                      in_font_data,
  input  logic [7:0]                      in_symbol_code,
  input  logic [7:0]                      in_attribute_byte,
  input  logic [6:0]                      in_cell_column,
  input  logic [5:0]                      in_cell_row,
  input  logic [3:0]                      in_glyph_line,
  input  tmgr_pkg::q_stat_t               q_stat,
  output logic                            enq,
  output tmgr_pkg::op_t                   enq_op
);
  import tmgr_pkg::*;

  localparam logic [FONT_ADDR_W:0] FONT_LIMIT = (FONT_ADDR_W+1)'(FONT_BYTES);
  localparam logic [7:0]           COL_LIMIT  = 8'(TEXT_COLUMNS);

  logic [1:0] height_mode_r;
  logic       interactive_r;
  logic       shown_r;
  logic       blinks_r;
  logic [6:0] ccol_r;
  logic [5:0] crow_r;
  logic [6:0] rows_r;
  logic [4:0] blink_r;
  logic [4:0] blink_nxt;

  logic              accept;
  logic              font_ok;
  logic [4:0]        height;
  logic [ADDR_W-1:0] base;
  logic [ADDR_W-1:0] sym_off;
  logic [ADDR_W-1:0] rd_addr;
  logic [4:0]        blink_inc;
  logic              cursor_on;
  logic              cell_hit;
  logic              line_hit;

  assign accept  = push && !q_stat.full;
  assign font_ok = {1'b0, in_font_address} < FONT_LIMIT;

  always_comb begin
    unique case (height_mode_r)
      HM_16: begin
        height  = 5'd16;
        base    = '0;
        sym_off = ADDR_W'({in_symbol_code, 4'b0});
      end
      HM_12: begin
        height  = 5'd12;
        base    = ADDR_W'(BASE_12);
        sym_off = ADDR_W'({in_symbol_code, 3'b0}) + ADDR_W'({in_symbol_code, 2'b0});
      end
      default: begin
        height  = 5'd8;
        base    = ADDR_W'(BASE_8);
        sym_off = ADDR_W'({in_symbol_code, 3'b0});
      end
    endcase
  end

  assign rd_addr   = base + sym_off + ADDR_W'(in_glyph_line);
  assign blink_inc = blink_r + 5'd1;

  assign cursor_on = shown_r && (!blinks_r || blink_inc[3]) &&
                     ({1'b0, ccol_r} < COL_LIMIT) && ({1'b0, crow_r} < rows_r);
  assign cell_hit  = (in_cell_column == ccol_r) && (in_cell_row == crow_r);
  assign line_hit  = ({1'b0, in_glyph_line} == height - 5'd2) ||
                     ({1'b0, in_glyph_line} == height - 5'd1);

  always_comb begin
    enq_op.is_write = 1'b0;
    enq_op.addr     = rd_addr;
    enq_op.data     = in_font_data;
    enq_op.line_ok  = {1'b0, in_glyph_line} < height;
    enq_op.cursor   = cursor_on && cell_hit && line_hit;
    enq_op.raw_fg   = in_attribute_byte[3:0];
    enq_op.fg       = (in_attribute_byte[7] && !interactive_r && blink_r[4]) ?
                      4'd0 : in_attribute_byte[3:0];
    enq_op.bg       = in_attribute_byte[6:4];
    enq             = 1'b0;
    blink_nxt       = blink_r;
    unique case (cmd_t'(in_cmd))
      CMD_FONT: begin
        enq_op.is_write = 1'b1;
        enq_op.addr     = ADDR_W'(in_font_address);
        enq             = accept && font_ok;
      end
      CMD_RENDER: begin
        enq = accept;
      end
      CMD_FRAME: begin
        if (accept) begin
          blink_nxt = blink_inc;
        end
      end
      default: begin
        enq = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      height_mode_r <= '0;
      interactive_r <= 1'b0;
      shown_r       <= 1'b0;
      blinks_r      <= 1'b0;
      ccol_r        <= '0;
      crow_r        <= '0;
      rows_r        <= 7'd30;
      blink_r       <= '0;
    end else begin
      blink_r <= blink_nxt;
      if (cfg_we) begin
        unique case (reg_idx_t'(cfg_index))
          REG_HEIGHT_MODE:   height_mode_r <= cfg_data[1:0];
          REG_INTERACTIVE:   interactive_r <= cfg_data[0];
          REG_CURSOR_SHOWN:  shown_r       <= cfg_data[0];
          REG_CURSOR_BLINKS: blinks_r      <= cfg_data[0];
          REG_CURSOR_COL:    ccol_r        <= cfg_data[6:0];
          REG_CURSOR_ROW:    crow_r        <= cfg_data[5:0];
          REG_ROW_COUNT:     rows_r        <= cfg_data[6:0];
          default: ;
        endcase
      end
    end
  end

endmodule

[src/tmgr_queue.sv]
module tmgr_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              enq,
  input  tmgr_pkg::op_t     enq_op,
  input  logic              deq,
  output tmgr_pkg::op_t     head_op,
  output tmgr_pkg::q_stat_t stat
);
  import tmgr_pkg::*;

  localparam logic [MQ_PW-1:0] LAST = MQ_PW'(MQ_DEPTH - 1);

  op_t              mem_r [MQ_DEPTH];
  logic [MQ_PW-1:0] wp_r;
  logic [MQ_PW-1:0] rp_r;
  logic [MQ_PW:0]   cnt_r;
  logic [MQ_PW-1:0] wp_nxt;
  logic [MQ_PW-1:0] rp_nxt;
  logic [MQ_PW:0]   cnt_nxt;

  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == (MQ_PW+1)'(MQ_DEPTH));
  assign head_op    = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (enq) begin
      wp_nxt  = (wp_r == LAST) ? '0 : wp_r + 1'b1;
      cnt_nxt = cnt_nxt + 1'b1;
    end
    if (deq) begin
      rp_nxt  = (rp_r == LAST) ? '0 : rp_r + 1'b1;
      cnt_nxt = cnt_nxt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      mem_r[wp_r] <= enq_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[src/tmgr_back.sv]
module tmgr_back (
  input  logic               clk,
  input  logic               rst_n,
  input  tmgr_pkg::op_t      head_op,
  input  tmgr_pkg::q_stat_t  q_stat,
  output logic               deq,
  input  logic               pop,
  output logic               empty,
  output tmgr_pkg::pix_row_t out_row
);
  import tmgr_pkg::*;

  localparam logic [OQ_PW-1:0] LAST  = OQ_PW'(OQ_DEPTH - 1);
  localparam logic [OQ_PW+1:0] LIMIT = (OQ_PW+2)'(OQ_DEPTH);

  logic       s1_valid_r;
  op_t        s1_op_r;
  logic [7:0] glyph_bits;
  pix_row_t   row;

  pix_row_t         oq_mem_r [OQ_DEPTH];
  logic [OQ_PW-1:0] oq_wp_r;
  logic [OQ_PW-1:0] oq_rp_r;
  logic [OQ_PW:0]   oq_cnt_r;
  logic [OQ_PW-1:0] oq_wp_nxt;
  logic [OQ_PW-1:0] oq_rp_nxt;
  logic [OQ_PW:0]   oq_cnt_nxt;
  logic             oq_pop;

  // reserve an output slot for every render in flight
  assign deq = !q_stat.empty &&
               (head_op.is_write ||
                (({1'b0, oq_cnt_r} + (OQ_PW+2)'(s1_valid_r)) < LIMIT));

  tmgr_ram #(
    .WIDTH(8),
    .DEPTH(FONT_BYTES)
  ) u_glyph_ram (
    .clk     (clk),
    .we      (deq && head_op.is_write),
    .addr    (head_op.addr),
    .wr_data (head_op.data),
    .rd_data (glyph_bits)
  );

  always_ff @(posedge clk) begin
    s1_op_r <= head_op;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= deq && !head_op.is_write;
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      if (s1_op_r.cursor) begin
        row[i] = s1_op_r.raw_fg;
      end else if (!s1_op_r.line_ok) begin
        row[i] = {1'b0, s1_op_r.bg};
      end else if (glyph_bits[3'(7 - i)]) begin
        row[i] = s1_op_r.fg;
      end else begin
        row[i] = {1'b0, s1_op_r.bg};
      end
    end
  end

  // result queue
  assign empty   = (oq_cnt_r == '0);
  assign oq_pop  = pop && !empty;
  assign out_row = oq_mem_r[oq_rp_r];

  always_comb begin
    oq_wp_nxt  = oq_wp_r;
    oq_rp_nxt  = oq_rp_r;
    oq_cnt_nxt = oq_cnt_r;
    if (s1_valid_r) begin
      oq_wp_nxt  = (oq_wp_r == LAST) ? '0 : oq_wp_r + 1'b1;
      oq_cnt_nxt = oq_cnt_nxt + 1'b1;
    end
    if (oq_pop) begin
      oq_rp_nxt  = (oq_rp_r == LAST) ? '0 : oq_rp_r + 1'b1;
      oq_cnt_nxt = oq_cnt_nxt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      oq_mem_r[oq_wp_r] <= row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wp_r  <= '0;
      oq_rp_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      oq_wp_r  <= oq_wp_nxt;
      oq_rp_r  <= oq_rp_nxt;
      oq_cnt_r <= oq_cnt_nxt;
    end
  end

endmodule

[src/text_mode_glyph_renderer_core.sv]
// channel   | direction | handshake          | payload
// ----------+-----------+--------------------+-------------------------------------
// cfg       | in        | cfg_we             | cfg_index, cfg_data
// input     | in        | push / full        | in_cmd, font and cell fields
// result    | out       | empty / pop        | out_pixel_0 .. out_pixel_7
//
// one beat per clock unless stalled; renders pass command queue, ram, result queue
// the single glyph ram port takes one font write or one glyph read per cycle
// four-entry command queue and four-entry result queue absorb stalls on either side
// synchronous reset clears queues and blink count, resets registers; glyph ram is not cleared
module text_mode_glyph_renderer_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [tmgr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tmgr_pkg::CFG_W-1:0]       cfg_data,
  input  logic                             push,
  output logic                             full,
  input  logic [1:0]                       in_cmd,
  input  logic [tmgr_pkg::FONT_ADDR_W-1:0] in_font_address,
  input  logic [7:0]                       in_font_data,
  input  logic [7:0]                       in_symbol_code,
  input  logic [7:0]                       in_attribute_byte,
  input  logic [6:0]                       in_cell_column,
  input  logic [5:0]                       in_cell_row,
  input  logic [3:0]                       in_glyph_line,
  output logic                             empty,
  input  logic                             pop,
  output tmgr_pkg::color_t                 out_pixel_0,
  output tmgr_pkg::color_t                 out_pixel_1,
  output tmgr_pkg::color_t                 out_pixel_2,
  output tmgr_pkg::color_t                 out_pixel_3,
  output tmgr_pkg::color_t                 out_pixel_4,
  output tmgr_pkg::color_t                 out_pixel_5,
  output tmgr_pkg::color_t                 out_pixel_6,
  output tmgr_pkg::color_t                 out_pixel_7
);
  import tmgr_pkg::*;

  logic     enq;
  op_t      enq_op;
  logic     deq;
  op_t      head_op;
  q_stat_t  q_stat;
  pix_row_t out_row;

  tmgr_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .push              (push),
    .in_cmd            (in_cmd),
    .in_font_address   (in_font_address),
    .in_font_data      (in_font_data),
    .in_symbol_code    (in_symbol_code),
    .in_attribute_byte (in_attribute_byte),
    .in_cell_column    (in_cell_column),
    .in_cell_row       (in_cell_row),
    .in_glyph_line     (in_glyph_line),
    .q_stat            (q_stat),
    .enq               (enq),
    .enq_op            (enq_op)
  );

  tmgr_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .enq     (enq),
    .enq_op  (enq_op),
    .deq     (deq),
    .head_op (head_op),
    .stat    (q_stat)
  );

  tmgr_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head_op (head_op),
    .q_stat  (q_stat),
    .deq     (deq),
    .pop     (pop),
    .empty   (empty),
    .out_row (out_row)
  );

  assign full        = q_stat.full;
  assign out_pixel_0 = out_row[0];
  assign out_pixel_1 = out_row[1];
  assign out_pixel_2 = out_row[2];
  assign out_pixel_3 = out_row[3];
  assign out_pixel_4 = out_row[4];
  assign out_pixel_5 = out_row[5];
  assign out_pixel_6 = out_row[6];
  assign out_pixel_7 = out_row[7];

endmodule

[src/tmgr_checker.sv]
`include "text_mode_glyph_renderer_core_macros.svh"

module tmgr_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             push,
  input logic             full,
  input logic             empty,
  input logic             pop,
  input tmgr_pkg::color_t out_pixel_0,
  input tmgr_pkg::color_t out_pixel_1,
  input tmgr_pkg::color_t out_pixel_2,
  input tmgr_pkg::color_t out_pixel_3,
  input tmgr_pkg::color_t out_pixel_4,
  input tmgr_pkg::color_t out_pixel_5,
  input tmgr_pkg::color_t out_pixel_6,
  input tmgr_pkg::color_t out_pixel_7
);
  import tmgr_pkg::*;

  pix_row_t out_row;

  assign out_row = {out_pixel_7, out_pixel_6, out_pixel_5, out_pixel_4,
                    out_pixel_3, out_pixel_2, out_pixel_1, out_pixel_0};

  `TMGR_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> empty, "result side not empty after reset")
  `TMGR_ASSERT_ALWAYS(a_rst_not_full, !rst_n |=> !full, "input side full after reset")
  `TMGR_ASSERT(a_full_needs_push, !full && !push |=> !full, "full rose with no input beat")
  `TMGR_ASSERT(a_result_holds, !empty && !pop |=> !empty && $stable(out_row), "result lost")

endmodule

bind text_mode_glyph_renderer_core tmgr_checker u_checker (.*);
